[sv/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared widths, constants and types of the HSV to RGB colour converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int unsigned HUE_W             = 15;
   localparam int unsigned SV_W              = 17;
   localparam int unsigned CH_W              = 8;
   localparam int unsigned PACK_W            = 24;

   localparam int unsigned FRAC_BITS_DEF     = 16;
   localparam int unsigned HUE_FRAC_BITS_DEF = 6;

   localparam int unsigned SEXT_DEG          = 60;
   localparam int unsigned TURN_DEG          = 360;
   localparam int unsigned NUM_SEXT          = 6;
   localparam int unsigned CH_MAX            = 255;

   typedef enum logic [2:0] {
      SEXT_0 = 3'd0,
      SEXT_1 = 3'd1,
      SEXT_2 = 3'd2,
      SEXT_3 = 3'd3,
      SEXT_4 = 3'd4,
      SEXT_5 = 3'd5
   } sextant_type;

   typedef struct packed {
      logic load_prod;
      logic load_frac;
   } div_ctl_type;

endpackage

[sv/hsvrgb_if.sv]
// ----------------------------------------------------------------------------
// hsvrgb_req_if / hsvrgb_rsp_if
// Valid/ready channels carrying one HSV pixel in and one RGB pixel out.
// ----------------------------------------------------------------------------
interface hsvrgb_req_if;
   logic                           valid;
   logic                           ready;
   logic [hsvrgb_pkg::HUE_W-1:0]   hue;
   logic [hsvrgb_pkg::SV_W-1:0]    saturation;
   logic [hsvrgb_pkg::SV_W-1:0]    brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [hsvrgb_pkg::CH_W-1:0]    red;
   logic [hsvrgb_pkg::CH_W-1:0]    green;
   logic [hsvrgb_pkg::CH_W-1:0]    blue;
   logic [hsvrgb_pkg::PACK_W-1:0]  packed_color;
   logic                           range_error;

   modport source (output valid, red, green, blue, packed_color, range_error,
                   input ready);
   modport sink   (input valid, red, green, blue, packed_color, range_error,
                   output ready);
endinterface

[sv/hsv_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top: HSV to RGB pixel converter, seven register stages
// Throughput: one transaction per clock unless rsp_bus back-pressure stalls
// the pipeline; no multiplier is shared between stages.
// Reset clears all stage valid bits; pipeline payload registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top #(
   parameter int unsigned FRAC_BITS     = hsvrgb_pkg::FRAC_BITS_DEF,
   parameter int unsigned HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   hsvrgb_req_if.sink    req_bus,
   hsvrgb_rsp_if.source  rsp_bus
);
   import hsvrgb_pkg::*;

   localparam int unsigned NUM_STG    = 7;
   localparam int unsigned SEXT_UNITS = SEXT_DEG << HUE_FRAC_BITS;
   localparam int unsigned REM_W      = $clog2(SEXT_UNITS);
   localparam int unsigned ONE_W      = FRAC_BITS + 1;
   localparam int unsigned SF_W       = SV_W + FRAC_BITS;
   localparam int unsigned SC_W       = SV_W + FRAC_BITS + 1;
   localparam int unsigned LP_W       = SV_W + FRAC_BITS + 1;
   localparam int unsigned LVL_W      = 2 * FRAC_BITS + 1;
   localparam int unsigned CW         = LVL_W + CH_W;

   localparam logic [31:0]      ONE_C   = 32'd1 << FRAC_BITS;
   localparam logic [31:0]      SEXT_C  = 32'(SEXT_UNITS);
   localparam logic [31:0]      TURN_C  = 32'(TURN_DEG) << HUE_FRAC_BITS;
   localparam logic [ONE_W-1:0] ONE_L   = ONE_W'(1) << FRAC_BITS;
   localparam logic [SC_W-1:0]  HALF_C  = SC_W'(1) << (FRAC_BITS - 1);
   localparam logic [CW-1:0]    HALF2_C = CW'(1) << (2 * FRAC_BITS - 1);

   logic [NUM_STG-1:0] vld_ff;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG-1:0] rdy;

   // side-band carried along the stages
   sextant_type        sext_ff [0:5];
   logic               err_ff  [0:5];
   logic [SV_W-1:0]    s_ff    [0:2];
   logic [SV_W-1:0]    v_ff    [0:4];

   logic [31:0]        hue_wrap;
   logic [31:0]        hue_base;
   sextant_type        sext_in;
   logic               err_in;
   logic [REM_W-1:0]   rem_in;
   logic [REM_W-1:0]   rem_ff;

   div_ctl_type        div_ctl;
   logic [FRAC_BITS-1:0] frac;

   logic [SF_W-1:0]    sf_ff;
   logic [SC_W-1:0]    sc_ff;
   logic [ONE_W-1:0]   ap_in;
   logic [ONE_W-1:0]   ap_ff;

   logic [SC_W-1:0]    sum_q;
   logic [SC_W-1:0]    sum_t;
   logic [ONE_W-1:0]   aq_in;
   logic [ONE_W-1:0]   at_in;
   logic [ONE_W-1:0]   aq_ff;
   logic [ONE_W-1:0]   at_ff;
   logic [ONE_W-1:0]   ap2_ff;

   logic [LVL_W-1:0]   lp_ff;
   logic [LVL_W-1:0]   lq_ff;
   logic [LVL_W-1:0]   lt_ff;
   logic [LVL_W-1:0]   lv_ff;

   logic [LVL_W-1:0]   lvl_sel [0:2];
   logic [CW-1:0]      ch_wide [0:2];
   logic [CH_W-1:0]    ch_in   [0:2];

   logic [CH_W-1:0]    red_ff;
   logic [CH_W-1:0]    green_ff;
   logic [CH_W-1:0]    blue_ff;
   logic               range_error_ff;

   // per-stage handshake: a stage loads when empty or when its successor loads
   always_comb begin
      rdy[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_bus.ready;
      for (int i = NUM_STG - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < NUM_STG; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = rdy[0];

   // stage 0: range check, hue wrap, sextant and remainder
   always_comb begin
      err_in = (32'(req_bus.saturation) > ONE_C) || (32'(req_bus.brightness) > ONE_C)
               || (32'(req_bus.hue) > TURN_C);
      hue_wrap = (32'(req_bus.hue) == TURN_C) ? 32'd0 : 32'(req_bus.hue);
      sext_in  = SEXT_0;
      hue_base = 32'd0;
      for (int k = 1; k < NUM_SEXT; k++) begin
         if (hue_wrap >= 32'(k) * SEXT_C) begin
            sext_in  = sextant_type'(3'(k));
            hue_base = 32'(k) * SEXT_C;
         end
      end
      rem_in = REM_W'(hue_wrap - hue_base);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         sext_ff[0] <= sext_in;
         err_ff[0]  <= err_in;
         s_ff[0]    <= req_bus.saturation;
         v_ff[0]    <= req_bus.brightness;
         rem_ff     <= rem_in;
      end
      for (int i = 1; i < 6; i++) begin
         if (rdy[i]) begin
            sext_ff[i] <= sext_ff[i-1];
            err_ff[i]  <= err_ff[i-1];
         end
      end
      for (int i = 1; i < 3; i++) begin
         if (rdy[i]) begin
            s_ff[i] <= s_ff[i-1];
         end
      end
      for (int i = 1; i < 5; i++) begin
         if (rdy[i]) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // stages 1 and 2: hue fraction
   assign div_ctl.load_prod = rdy[1];
   assign div_ctl.load_frac = rdy[2];

   hsvrgb_frac_div #(
      .FRAC_BITS     (FRAC_BITS),
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_frac_div (
      .clock (clock),
      .ctl   (div_ctl),
      .rem   (rem_ff),
      .frac  (frac)
   );

   // stage 3: s*f, s*(1-f) and 1-s
   assign ap_in = ONE_L - ONE_W'(s_ff[2]);

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         sf_ff <= SF_W'(s_ff[2]) * SF_W'(frac);
         sc_ff <= SC_W'(s_ff[2]) * SC_W'(ONE_L - ONE_W'(frac));
         ap_ff <= ap_in;
      end
   end

   // stage 4: round the products and form the (1 - x) factors
   always_comb begin
      sum_q = SC_W'(sf_ff) + HALF_C;
      sum_t = sc_ff + HALF_C;
      aq_in = ONE_L - ONE_W'(sum_q >> FRAC_BITS);
      at_in = ONE_L - ONE_W'(sum_t >> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         aq_ff  <= aq_in;
         at_ff  <= at_in;
         ap2_ff <= ap_ff;
      end
   end

   // stage 5: levels p, q, t and v at twice the fraction bits
   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         lp_ff <= LVL_W'(LP_W'(v_ff[4]) * LP_W'(ap2_ff));
         lq_ff <= LVL_W'(LP_W'(v_ff[4]) * LP_W'(aq_ff));
         lt_ff <= LVL_W'(LP_W'(v_ff[4]) * LP_W'(at_ff));
         lv_ff <= LVL_W'(v_ff[4]) << FRAC_BITS;
      end
   end

   // stage 6: sextant mapping, scale by 255, round half up, zero on range error
   always_comb begin
      unique case (sext_ff[5])
         SEXT_0: begin
            lvl_sel[0] = lv_ff; lvl_sel[1] = lt_ff; lvl_sel[2] = lp_ff;
         end
         SEXT_1: begin
            lvl_sel[0] = lq_ff; lvl_sel[1] = lv_ff; lvl_sel[2] = lp_ff;
         end
         SEXT_2: begin
            lvl_sel[0] = lp_ff; lvl_sel[1] = lv_ff; lvl_sel[2] = lt_ff;
         end
         SEXT_3: begin
            lvl_sel[0] = lp_ff; lvl_sel[1] = lq_ff; lvl_sel[2] = lv_ff;
         end
         SEXT_4: begin
            lvl_sel[0] = lt_ff; lvl_sel[1] = lp_ff; lvl_sel[2] = lv_ff;
         end
         SEXT_5: begin
            lvl_sel[0] = lv_ff; lvl_sel[1] = lp_ff; lvl_sel[2] = lq_ff;
         end
         default: begin
            lvl_sel[0] = lv_ff; lvl_sel[1] = lp_ff; lvl_sel[2] = lq_ff;
         end
      endcase
      for (int c = 0; c < 3; c++) begin
         ch_wide[c] = CW'(lvl_sel[c]) * CW'(CH_MAX) + HALF2_C;
         ch_in[c]   = ch_wide[c][2*FRAC_BITS +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         red_ff         <= err_ff[5] ? '0 : ch_in[0];
         green_ff       <= err_ff[5] ? '0 : ch_in[1];
         blue_ff        <= err_ff[5] ? '0 : ch_in[2];
         range_error_ff <= err_ff[5];
      end
   end

   assign rsp_bus.valid        = vld_ff[NUM_STG-1];
   assign rsp_bus.red          = red_ff;
   assign rsp_bus.green        = green_ff;
   assign rsp_bus.blue         = blue_ff;
   assign rsp_bus.packed_color = {red_ff, green_ff, blue_ff};
   assign rsp_bus.range_error  = range_error_ff;

endmodule

[sv/hsvrgb_frac_div.sv]
// ----------------------------------------------------------------------------
// hsvrgb_frac_div
// Two-stage constant divider: frac = floor(rem * 2^FRAC_BITS / sextant width),
// by reciprocal multiply followed by a single compare-and-correct step.
// ----------------------------------------------------------------------------
module hsvrgb_frac_div #(
   parameter int unsigned FRAC_BITS     = hsvrgb_pkg::FRAC_BITS_DEF,
   parameter int unsigned HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
   input  logic                                                        clock,
   input  hsvrgb_pkg::div_ctl_type                                     ctl,
   input  logic [$clog2(hsvrgb_pkg::SEXT_DEG << HUE_FRAC_BITS)-1:0]    rem,
   output logic [FRAC_BITS-1:0]                                        frac
);
   import hsvrgb_pkg::*;

   localparam int unsigned SEXT_UNITS = SEXT_DEG << HUE_FRAC_BITS;
   localparam int unsigned REM_W      = $clog2(SEXT_UNITS);
   localparam int unsigned NW         = REM_W + FRAC_BITS;
   // sextant width is never a power of two, so the reciprocal fits FRAC_BITS+1 bits
   localparam int unsigned M_W        = FRAC_BITS + 1;
   localparam int unsigned PRD_W      = NW + M_W;
   localparam logic [M_W-1:0] RECIP   = M_W'((64'd1 << NW) / 64'(SEXT_UNITS));
   localparam logic [NW-1:0]  DIV_C   = NW'(SEXT_UNITS);

   logic [NW-1:0]        num;
   logic [NW-1:0]        num_ff;
   logic [PRD_W-1:0]     prod_ff;
   logic [FRAC_BITS-1:0] quot;
   logic [NW-1:0]        resid;
   logic [FRAC_BITS-1:0] frac_ff;

   assign num = NW'(rem) << FRAC_BITS;

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         prod_ff <= PRD_W'(num) * PRD_W'(RECIP);
         num_ff  <= num;
      end
   end

   // estimate is exact or one short
   always_comb begin
      quot  = prod_ff[NW +: FRAC_BITS];
      resid = num_ff - (NW'(quot) * DIV_C);
   end

   always_ff @(posedge clock) begin
      if (ctl.load_frac) begin
         frac_ff <= quot + FRAC_BITS'(resid >= DIV_C);
      end
   end

   assign frac = frac_ff;

endmodule

[verif/tb_hsv_to_rgb_converter_top.sv]
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter_top
// Drives HSV pixels into the converter under random flow control, predicts
// each RGB result from the fixed-point arithmetic and checks it field by field.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_top;
   import hsvrgb_pkg::*;

   localparam longint unsigned ONE        = 64'd1 << FRAC_BITS_DEF;
   localparam longint unsigned SEXT_UNITS = 64'(SEXT_DEG) << HUE_FRAC_BITS_DEF;
   localparam longint unsigned FULL_TURN  = 64'(TURN_DEG) << HUE_FRAC_BITS_DEF;
   localparam int unsigned     HOLD_CYCLES = 80;
   localparam int unsigned     RANDOM_PER_PHASE = 270;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SV_W-1:0]  saturation;
      logic [SV_W-1:0]  brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [PACK_W-1:0] packed_color;
      logic              range_error;
   } rgb_pixel_type;

   logic clock;
   logic reset;

   hsvrgb_req_if req_bus ();
   hsvrgb_rsp_if rsp_bus ();

   hsv_to_rgb_converter_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hsv_pixel_type pending_pixels[$];
   rgb_pixel_type colours_due[$];
   hsv_pixel_type next_pixel;
   rgb_pixel_type want;

   int unsigned pixels_queued = 0;
   int unsigned pixels_in     = 0;
   int unsigned results_seen  = 0;
   int unsigned range_errors  = 0;
   int unsigned fail_cnt      = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        req_taken     = 1'b0;
   logic        rsp_hold      = 1'b0;
   logic        hold_go       = 1'b0;

   // (a * b) rounded back to FRAC_BITS fraction bits
   function automatic longint unsigned fx_mul_round(longint unsigned a, longint unsigned b);
      return (a * b + (ONE >> 1)) >> FRAC_BITS_DEF;
   endfunction

   // level at 2*FRAC_BITS fraction bits scaled to 0..255, half up
   function automatic logic [CH_W-1:0] level_to_channel(longint unsigned level);
      longint unsigned half;
      half = 64'd1 << (2 * FRAC_BITS_DEF - 1);
      return CH_W'((level * CH_MAX + half) >> (2 * FRAC_BITS_DEF));
   endfunction

   function automatic rgb_pixel_type convert_hsv(hsv_pixel_type px);
      rgb_pixel_type   rgb;
      longint unsigned h, s, v, rem, fr;
      longint unsigned lvl_v, lvl_p, lvl_q, lvl_t, lvl_r, lvl_g, lvl_b;
      logic [2:0]      sidx;
      sextant_type     sext;
      rgb = '0;
      h   = px.hue;
      s   = px.saturation;
      v   = px.brightness;
      if (s > ONE || v > ONE || h > FULL_TURN) begin
         rgb.range_error = 1'b1;
         return rgb;
      end
      if (h == FULL_TURN)
         h = 0;
      sidx  = 3'(h / SEXT_UNITS);
      sext  = sextant_type'(sidx);
      rem   = h % SEXT_UNITS;
      fr    = (rem << FRAC_BITS_DEF) / SEXT_UNITS;
      lvl_v = v << FRAC_BITS_DEF;
      lvl_p = v * (ONE - s);
      lvl_q = v * (ONE - fx_mul_round(s, fr));
      lvl_t = v * (ONE - fx_mul_round(s, ONE - fr));
      unique case (sext)
         SEXT_0: begin lvl_r = lvl_v; lvl_g = lvl_t; lvl_b = lvl_p; end
         SEXT_1: begin lvl_r = lvl_q; lvl_g = lvl_v; lvl_b = lvl_p; end
         SEXT_2: begin lvl_r = lvl_p; lvl_g = lvl_v; lvl_b = lvl_t; end
         SEXT_3: begin lvl_r = lvl_p; lvl_g = lvl_q; lvl_b = lvl_v; end
         SEXT_4: begin lvl_r = lvl_t; lvl_g = lvl_p; lvl_b = lvl_v; end
         default: begin lvl_r = lvl_v; lvl_g = lvl_p; lvl_b = lvl_q; end
      endcase
      rgb.red          = level_to_channel(lvl_r);
      rgb.green        = level_to_channel(lvl_g);
      rgb.blue         = level_to_channel(lvl_b);
      rgb.packed_color = {rgb.red, rgb.green, rgb.blue};
      return rgb;
   endfunction

   task automatic check_field(input string what, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp_v, act_v);
         fail_cnt++;
      end
   endtask

   task automatic add_pixel(input longint unsigned h, input longint unsigned s,
                            input longint unsigned v);
      hsv_pixel_type px;
      px.hue        = HUE_W'(h);
      px.saturation = SV_W'(s);
      px.brightness = SV_W'(v);
      pending_pixels.push_back(px);
      pixels_queued++;
   endtask

   // always in range, with a bias towards the extremes
   function automatic logic [SV_W-1:0] rand_level();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return SV_W'(ONE);
         default: return SV_W'($urandom_range(32'(ONE), 0));
      endcase
   endfunction

   task automatic add_random_pixels(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++) begin
         case ($urandom_range(19, 0))
            0: add_pixel(HUE_W'($urandom_range(2**HUE_W - 1, 32'(FULL_TURN + 1))),
                         rand_level(), rand_level());
            1: add_pixel(HUE_W'($urandom_range(32'(FULL_TURN), 0)),
                         SV_W'($urandom_range(2**SV_W - 1, 32'(ONE + 1))), rand_level());
            2: add_pixel(HUE_W'($urandom_range(32'(FULL_TURN), 0)), rand_level(),
                         SV_W'($urandom_range(2**SV_W - 1, 32'(ONE + 1))));
            3: add_pixel(HUE_W'($urandom), SV_W'($urandom), SV_W'($urandom));
            default: add_pixel(HUE_W'($urandom_range(32'(FULL_TURN), 0)), rand_level(),
                               rand_level());
         endcase
      end
   endtask

   // stimulus waits until every queued pixel has been sent and has come back
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || pixels_in != pixels_queued)
         @(posedge clock);
      while (results_seen != pixels_in)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.hue        = '0;
      req_bus.saturation = '0;
      req_bus.brightness = '0;
      rsp_bus.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // driver: a pixel stays on the bus until it has been taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_pixel          = pending_pixels.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.hue        <= next_pixel.hue;
               req_bus.saturation <= next_pixel.saturation;
               req_bus.brightness <= next_pixel.brightness;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor: check results before predicting this edge's new transaction
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (colours_due.size() == 0) begin
               $display("%0t: result with none expected, actual 0x%0h err %0b", $time,
                        rsp_bus.packed_color, rsp_bus.range_error);
               fail_cnt++;
            end else begin
               want = colours_due.pop_front();
               check_field("red", 32'(want.red), 32'(rsp_bus.red));
               check_field("green", 32'(want.green), 32'(rsp_bus.green));
               check_field("blue", 32'(want.blue), 32'(rsp_bus.blue));
               check_field("packed_color", 32'(want.packed_color), 32'(rsp_bus.packed_color));
               check_field("range_error", 32'(want.range_error), 32'(rsp_bus.range_error));
               if (want.range_error)
                  range_errors++;
               results_seen <= results_seen + 1;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            colours_due.push_back(convert_hsv({req_bus.hue, req_bus.saturation,
                                               req_bus.brightness}));
            pixels_in <= pixels_in + 1;
         end
      end
   end

   // long result back-pressure so the pipeline fills and stalls its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #4000000;
      $display("timeout with %0d pixels accepted, %0d results seen", pixels_in, results_seen);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      while (reset !== 1'b0)
         @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 72;
      // sextant boundaries, full-turn wrap, remainder limits and mixed s and v
      add_pixel(0, ONE, ONE);
      add_pixel(1, ONE, ONE);
      add_pixel(3839, ONE, ONE);
      add_pixel(3840, ONE, ONE);
      add_pixel(7680, ONE, ONE);
      add_pixel(11520, ONE, ONE);
      add_pixel(15360, ONE, ONE);
      add_pixel(19200, ONE, ONE);
      add_pixel(23039, ONE, ONE);
      add_pixel(23040, ONE, ONE);
      add_pixel(1920, 32768, ONE);
      add_pixel(5760, 65535, 65535);
      add_pixel(9600, 1, 1);
      add_pixel(13440, 0, ONE);
      add_pixel(17280, ONE, 0);
      add_pixel(21120, 40000, 50000);
      add_pixel(0, 0, 0);
      // out of range hue, saturation and value
      add_pixel(23041, 0, 0);
      add_pixel(2**HUE_W - 1, ONE, ONE);
      add_pixel(0, ONE + 1, ONE);
      add_pixel(0, ONE, ONE + 1);
      add_pixel(0, 2**SV_W - 1, 0);
      add_pixel(0, 0, 2**SV_W - 1);
      add_pixel(20000, 2**SV_W - 1, 2**SV_W - 1);
      add_random_pixels(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 72;
      recv_idle_pct = 34;
      add_random_pixels(RANDOM_PER_PHASE);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_pixels(RANDOM_PER_PHASE);
      hold_go = 1'b1;
      wait_drained();

      repeat (20) @(posedge clock);
      if (colours_due.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, colours_due.size());
         fail_cnt++;
      end
      $display("converted %0d pixels (%0d out of range) under three flow-control mixes",
               results_seen, range_errors);
      $display("and a %0d-cycle result stall; %0d mismatches", HOLD_CYCLES, fail_cnt);
      if (fail_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
